// ----- rtl/cnms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cnms_pkg;

  localparam int MagW     = 16;
  localparam int GradW    = 16;
  localparam int SizeW    = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int DefMaxWidth  = 2048;
  localparam int DefMaxHeight = 2048;

  localparam int FrameWidthRst  = 640;
  localparam int FrameHeightRst = 480;
  localparam int LowThrRst      = 1;
  localparam int MinSize        = 3;

  // Q16 tangents of 22.5 and 67.5 degrees
  localparam int TanNarrow = 27145;
  localparam int TanWide   = 158217;
  localparam int TanShift  = 16;
  localparam int NarrowW   = 31;
  localparam int WideW     = 34;
  localparam int AyW       = GradW + TanShift;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgLowThr      = CfgIdxW'(2);

  typedef struct packed {
    logic                    req_type;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    logic [MagW-1:0]         grad_mag;
  } in_word_t;

  typedef struct packed {
    logic [MagW-1:0] out_mag;
    logic            suppressed;
    logic            last_pixel;
  } out_word_t;

  // control that travels with each pipeline slot
  typedef struct packed {
    logic valid;
    logic has_res;
    logic border;
    logic last;
  } ctrl_t;

  // 3x3 magnitude window: [row][col], row 0 = top, col 0 = newest
  typedef logic [2:0][2:0][MagW-1:0] win_t;

  // largest size the 12-bit field can express under a given limit
  function automatic int size_limit(input int max_size);
    if (max_size > (1 << SizeW) - 1) return (1 << SizeW) - 1;
    return max_size;
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v, input int hi);
    if (v < SizeW'(MinSize)) return SizeW'(MinSize);
    if (int'(v) > hi) return SizeW'(hi);
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cnms_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cnms_line_buf #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             push_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]                wdata_i,
  output logic      [DATA_W-1:0]                rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read the word stored one line ago, then overwrite it
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cnms_nms_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cnms_nms_core import cnms_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire ctrl_t                   ctrl_i,
  input  wire win_t                    win_i,
  input  wire logic signed [GradW-1:0] grad_x_i,
  input  wire logic signed [GradW-1:0] grad_y_i,
  input  wire logic [MagW-1:0]         low_thr_i,
  output logic                         push_o,
  output out_word_t                    word_o
);

  logic [GradW-1:0]   ax, ay;
  logic [NarrowW-1:0] prod_n;
  logic [WideW-1:0]   prod_w;

  ctrl_t              c4_q, c5_q;
  win_t               win4_q;
  logic [AyW-1:0]     ay4_q;
  logic [NarrowW-1:0] pn4_q;
  logic [WideW-1:0]   pw4_q;
  logic               anti4_q;

  logic [MagW-1:0]    a_d, b_d;
  logic [MagW-1:0]    a5_q, b5_q, m5_q;
  logic               horiz, diag, test, supp;

  // stage 4 input: magnitudes of the gradient and the two tangent products
  always_comb begin
    ax     = grad_x_i[GradW-1] ? GradW'(-grad_x_i) : GradW'(grad_x_i);
    ay     = grad_y_i[GradW-1] ? GradW'(-grad_y_i) : GradW'(grad_y_i);
    prod_n = NarrowW'(TanNarrow) * NarrowW'(ax);
    prod_w = WideW'(TanWide) * WideW'(ax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c4_q <= ctrl_i;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win4_q  <= win_i;
      ay4_q   <= {ay, TanShift'(0)};
      pn4_q   <= prod_n;
      pw4_q   <= prod_w;
      anti4_q <= grad_x_i[GradW-1] ^ grad_y_i[GradW-1];
    end
  end

  // stage 5 input: pick the neighbor pair along the quantized direction
  always_comb begin
    horiz = WideW'(ay4_q) < WideW'(pn4_q);
    diag  = WideW'(ay4_q) < pw4_q;
    if (horiz) begin
      a_d = win4_q[1][2];
      b_d = win4_q[1][0];
    end else if (diag) begin
      if (anti4_q) begin
        a_d = win4_q[0][0];
        b_d = win4_q[2][2];
      end else begin
        a_d = win4_q[0][2];
        b_d = win4_q[2][0];
      end
    end else begin
      a_d = win4_q[0][1];
      b_d = win4_q[2][1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a5_q <= a_d;
      b5_q <= b_d;
      m5_q <= win4_q[1][1];
    end
  end

  always_comb begin
    test              = !c5_q.border && (m5_q >= low_thr_i);
    supp              = test && ((a5_q > m5_q) || (b5_q > m5_q));
    word_o.out_mag    = supp ? '0 : m5_q;
    word_o.suppressed = supp;
    word_o.last_pixel = c5_q.last;
    push_o            = en_i && c5_q.valid && c5_q.has_res;
  end

endmodule

`default_nettype wire

// ----- rtl/cnms_out_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cnms_out_skid import cnms_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_word_t push_data_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  logic      out_valid_q, sk_valid_q;
  out_word_t out_q, sk_q;
  logic      take;

  assign take = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (take) sk_valid_q <= 1'b0;
    end else if (push_i) begin
      if (!out_valid_q || take) out_valid_q <= 1'b1;
      else sk_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (take) out_q <= sk_q;
    end else if (push_i) begin
      if (!out_valid_q || take) out_q <= push_data_i;
      else sk_q <= push_data_i;
    end
  end

  assign ready_o     = !sk_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/canny_nonmax_suppression.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Canny non-maximum suppression on a raster stream of gradient pixels. The
// block takes one word per clock while the skid slot is empty and returns
// at most one result word per input word: the result for pixel p leaves
// once the word p + width + 1 of the frame has been taken, and reaches the
// output port through the pipeline stages and the output register. Send
// width + 1 drain words after the last pixel to flush the frame; the result
// flagged last_pixel closes it. Drain words that arrive before the frame is
// complete are dropped. While the output keeps up the rate is one word per
// cycle, set by the two line memories with one read and one write per word.
// The path runs through five register stages (line 1, line 2, window,
// tangent products, neighbor select) into an output register with a skid
// slot, so the input keeps flowing while one result waits. Line memories
// need no clearing after reset. Write frame_width or frame_height only while
// idle; either restarts the frame. low_threshold takes effect at once.
module canny_nonmax_suppression import cnms_pkg::*; #(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_word_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_word_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW   = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
  localparam int WLimit  = size_limit(MAX_WIDTH);
  localparam int HLimit  = size_limit(MAX_HEIGHT);
  localparam int LineW   = MagW + 2 * GradW;

  // configuration
  logic [SizeW-1:0] w_q, h_q;
  logic [MagW-1:0]  low_q;
  logic             cfg_we, size_we;

  // frame position: incoming word n and the pixel p whose result is due
  logic [SizeW-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [SizeW-1:0] p_col_q, p_col_d, p_row_q, p_row_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [SizeW-1:0] w_m1, h_m1;
  logic             in_done, warm, ignore, accept, push0, p_last, border;
  logic             en;

  // pipeline
  ctrl_t            c1_d, c1_q, c2_q, c3_q;
  logic [MagW-1:0]  mag1_q, mag2_q;
  logic [AddrW-1:0] ptr1_q;
  logic [LineW-1:0] line1_rd, mid2_q;
  logic [MagW-1:0]  line2_rd;
  win_t             win_q;
  logic [2*GradW-1:0] gp_q, gc_q;
  logic             res_push;
  out_word_t        res_word;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign size_we     = cfg_we && (cfg_index_i == CfgFrameWidth ||
                                  cfg_index_i == CfgFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= clamp_size(SizeW'(FrameWidthRst), WLimit);
      h_q   <= clamp_size(SizeW'(FrameHeightRst), HLimit);
      low_q <= MagW'(LowThrRst);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CfgFrameWidth:  w_q   <= clamp_size(cfg_data_i[SizeW-1:0], WLimit);
        CfgFrameHeight: h_q   <= clamp_size(cfg_data_i[SizeW-1:0], HLimit);
        CfgLowThr:      low_q <= cfg_data_i[MagW-1:0];
        default: ;
      endcase
    end
  end

  // Decide what the offered word does: drop it, only fill the lines during
  // the first width + 1 words, or also produce the result for pixel p.
  always_comb begin
    w_m1    = w_q - SizeW'(1);
    h_m1    = h_q - SizeW'(1);
    in_done = (in_row_q == h_q);
    warm    = (in_row_q == '0) || (in_row_q == SizeW'(1) && in_col_q == '0);
    ignore  = in_data_i.req_type && !in_done;
    accept  = in_valid_i && in_ready_o;
    push0   = accept && !ignore;
    p_last  = (p_row_q == h_m1) && (p_col_q == w_m1);
    border  = (p_row_q == '0) || (p_row_q == h_m1) ||
              (p_col_q == '0) || (p_col_q == w_m1);

    in_col_d = in_col_q;
    in_row_d = in_row_q;
    p_col_d  = p_col_q;
    p_row_d  = p_row_q;
    ptr_d    = ptr_q;

    if (size_we) begin
      in_col_d = '0;
      in_row_d = '0;
      p_col_d  = '0;
      p_row_d  = '0;
      ptr_d    = '0;
    end else if (push0) begin
      ptr_d = (ptr_q == AddrW'(w_m1)) ? '0 : ptr_q + AddrW'(1);
      if (!in_done) begin
        if (in_col_q == w_m1) begin
          in_col_d = '0;
          in_row_d = in_row_q + SizeW'(1);
        end else begin
          in_col_d = in_col_q + SizeW'(1);
        end
      end
      if (!warm) begin
        if (p_last) begin
          // frame closes: next word starts a new frame
          in_col_d = '0;
          in_row_d = '0;
          p_col_d  = '0;
          p_row_d  = '0;
        end else if (p_col_q == w_m1) begin
          p_col_d = '0;
          p_row_d = p_row_q + SizeW'(1);
        end else begin
          p_col_d = p_col_q + SizeW'(1);
        end
      end
    end

    c1_d.valid   = push0;
    c1_d.has_res = !warm;
    c1_d.border  = border;
    c1_d.last    = p_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      p_col_q  <= '0;
      p_row_q  <= '0;
      ptr_q    <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      p_col_q  <= p_col_d;
      p_row_q  <= p_row_d;
      ptr_q    <= ptr_d;
    end
  end

  // Valid bits advance together; the skid slot stalls all stages at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (en) begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  // Line 1 holds magnitude and gradient one line back.
  cnms_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LineW)
  ) u_line1 (
    .clk_i   (clk_i),
    .push_i  (push0),
    .addr_i  (ptr_q),
    .wdata_i ({in_data_i.grad_mag, in_data_i.grad_x, in_data_i.grad_y}),
    .rdata_o (line1_rd)
  );

  // Line 2 takes line 1's magnitude one stage later: two lines back.
  cnms_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (MagW)
  ) u_line2 (
    .clk_i   (clk_i),
    .push_i  (en && c1_q.valid),
    .addr_i  (ptr1_q),
    .wdata_i (line1_rd[LineW-1 -: MagW]),
    .rdata_o (line2_rd)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= in_data_i.grad_mag;
      ptr1_q <= ptr_q;
      mag2_q <= mag1_q;
      mid2_q <= line1_rd;
    end
  end

  // Shift a new column into the window; the center is pixel p, and its
  // gradient is the one that came out of line 1 one word earlier.
  always_ff @(posedge clk_i) begin
    if (en && c2_q.valid) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][2] <= win_q[r][1];
        win_q[r][1] <= win_q[r][0];
      end
      win_q[0][0] <= line2_rd;
      win_q[1][0] <= mid2_q[LineW-1 -: MagW];
      win_q[2][0] <= mag2_q;
      gc_q        <= gp_q;
      gp_q        <= mid2_q[2*GradW-1:0];
    end
  end

  cnms_nms_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctrl_i    (c3_q),
    .win_i     (win_q),
    .grad_x_i  (gc_q[2*GradW-1:GradW]),
    .grad_y_i  (gc_q[GradW-1:0]),
    .low_thr_i (low_q),
    .push_o    (res_push),
    .word_o    (res_word)
  );

  cnms_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_word),
    .ready_o     (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign in_ready_o = en;

  // input stalls only while a result sits in the skid slot behind the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // the due pixel never runs ahead of the incoming word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_row_q <= in_row_q)
    else $error("result row ahead of input row");

  // position counters stay inside the configured frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= h_q && p_col_q < w_q && in_col_q < w_q)
    else $error("frame position out of range");

endmodule

`default_nettype wire
